[rtl/fcc_pkg.sv]
package fcc_pkg;

    localparam int NUM_PLANES         = 6;
    localparam int DEFAULT_COORD_BITS = 16;

    localparam int PLANE_W     = 64;
    localparam int COEF_W      = 16;
    localparam int FRAC_BITS   = 14;
    localparam int RADIUS_W    = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int VERDICT_W   = 2;

    localparam logic [VERDICT_W-1:0] VERDICT_OUT   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_CROSS = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_IN    = 2'd2;

    // Per-plane decision flags handed from a plane lane to the verdict stage
    typedef struct packed {
        logic sph_out;    // center distance below minus radius
        logic sph_cross;  // absolute center distance below radius
        logic box_all;    // every corner behind the plane
        logic box_none;   // no corner behind the plane
    } t_plane_flags;

endpackage

[rtl/fcc_plane_regs.sv]
module fcc_plane_regs #(
    parameter int PLANE_COUNT = fcc_pkg::NUM_PLANES
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_we,
    input  logic [fcc_pkg::CFG_INDEX_W-1:0]                i_index,
    input  logic [fcc_pkg::PLANE_W-1:0]                    i_data,
    output logic [PLANE_COUNT-1:0][fcc_pkg::PLANE_W-1:0]   o_planes
);
    import fcc_pkg::*;

    logic [PLANE_COUNT-1:0][PLANE_W-1:0] r_plane;

    // Writes to an index with no plane behind it are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_we) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                if (i_index == CFG_INDEX_W'(p)) begin
                    r_plane[p] <= i_data;
                end
            end
        end
    end

    assign o_planes = r_plane;

endmodule

[rtl/fcc_plane_lane.sv]
module fcc_plane_lane #(
    parameter int COORD_BITS = fcc_pkg::DEFAULT_COORD_BITS
) (
    input  logic                              i_clk,
    input  logic [fcc_pkg::PLANE_W-1:0]       i_plane,
    input  logic signed [COORD_BITS-1:0]      i_x_lo,
    input  logic signed [COORD_BITS-1:0]      i_y_lo,
    input  logic signed [COORD_BITS-1:0]      i_z_lo,
    input  logic signed [COORD_BITS-1:0]      i_x_hi,
    input  logic signed [COORD_BITS-1:0]      i_y_hi,
    input  logic signed [COORD_BITS-1:0]      i_z_hi,
    input  logic [fcc_pkg::RADIUS_W-1:0]      i_radius,
    output fcc_pkg::t_plane_flags             o_flags
);
    import fcc_pkg::*;

    localparam int PROD_W = COEF_W + COORD_BITS;
    localparam int SUM_W  = (PROD_W + 2 > 32) ? PROD_W + 2 : 32;
    localparam int DSH_W  = COEF_W + FRAC_BITS;
    localparam int RSH_W  = RADIUS_W + FRAC_BITS;

    logic signed [COEF_W-1:0] a_coef, b_coef, c_coef, d_coef;

    assign a_coef = i_plane[COEF_W-1:0];
    assign b_coef = i_plane[2*COEF_W-1:COEF_W];
    assign c_coef = i_plane[3*COEF_W-1:2*COEF_W];
    assign d_coef = i_plane[4*COEF_W-1:3*COEF_W];

    // Stage 1: the six axis products
    logic signed [PROD_W-1:0] r_px_lo, r_py_lo, r_pz_lo;
    logic signed [PROD_W-1:0] r_px_hi, r_py_hi, r_pz_hi;

    always_ff @(posedge i_clk) begin
        r_px_lo <= a_coef * i_x_lo;
        r_px_hi <= a_coef * i_x_hi;
        r_py_lo <= b_coef * i_y_lo;
        r_py_hi <= b_coef * i_y_hi;
        r_pz_lo <= c_coef * i_z_lo;
        r_pz_hi <= c_coef * i_z_hi;
    end

    function automatic logic signed [SUM_W-1:0] sext(input logic signed [PROD_W-1:0] v);
        sext = {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    // Stage 2: pick the nearest and farthest corner per axis, sum x and y
    logic signed [PROD_W-1:0] mn_x, mx_x, mn_y, mx_y, mn_z, mx_z;

    assign mn_x = (r_px_lo < r_px_hi) ? r_px_lo : r_px_hi;
    assign mx_x = (r_px_lo < r_px_hi) ? r_px_hi : r_px_lo;
    assign mn_y = (r_py_lo < r_py_hi) ? r_py_lo : r_py_hi;
    assign mx_y = (r_py_lo < r_py_hi) ? r_py_hi : r_py_lo;
    assign mn_z = (r_pz_lo < r_pz_hi) ? r_pz_lo : r_pz_hi;
    assign mx_z = (r_pz_lo < r_pz_hi) ? r_pz_hi : r_pz_lo;

    logic signed [SUM_W-1:0]  r_sph_xy, r_min_xy, r_max_xy;
    logic signed [PROD_W-1:0] r_sph_z, r_min_z, r_max_z;

    always_ff @(posedge i_clk) begin
        r_sph_xy <= sext(r_px_lo) + sext(r_py_lo);
        r_min_xy <= sext(mn_x) + sext(mn_y);
        r_max_xy <= sext(mx_x) + sext(mx_y);
        r_sph_z  <= r_pz_lo;
        r_min_z  <= mn_z;
        r_max_z  <= mx_z;
    end

    // Stage 3: add z and the offset, compare against zero and the radius
    logic signed [SUM_W-1:0] d_term, r_term, r_neg;
    logic signed [SUM_W-1:0] sph_dist, min_dist, max_dist;

    assign d_term   = {{(SUM_W-DSH_W){d_coef[COEF_W-1]}}, d_coef, {FRAC_BITS{1'b0}}};
    assign r_term   = {{(SUM_W-RSH_W){1'b0}}, i_radius, {FRAC_BITS{1'b0}}};
    assign r_neg    = -r_term;
    assign sph_dist = r_sph_xy + sext(r_sph_z) + d_term;
    assign min_dist = r_min_xy + sext(r_min_z) + d_term;
    assign max_dist = r_max_xy + sext(r_max_z) + d_term;

    t_plane_flags r_flags;

    always_ff @(posedge i_clk) begin
        r_flags.sph_out   <= sph_dist < r_neg;
        r_flags.sph_cross <= (sph_dist < r_term) && (sph_dist > r_neg);
        r_flags.box_all   <= max_dist[SUM_W-1];
        r_flags.box_none  <= !min_dist[SUM_W-1];
    end

    assign o_flags = r_flags;

endmodule

[rtl/fcc_verdict.sv]
module fcc_verdict #(
    parameter int PLANE_COUNT = fcc_pkg::NUM_PLANES
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic                                      i_func,
    input  fcc_pkg::t_plane_flags [PLANE_COUNT-1:0]   i_flags,
    output logic                                      o_valid,
    output logic [fcc_pkg::VERDICT_W-1:0]             o_verdict
);
    import fcc_pkg::*;

    logic                 any_all, all_none, no_sph;
    logic [VERDICT_W-1:0] sph_verdict, box_verdict;
    logic [VERDICT_W-1:0] n_verdict;

    // Walk from the last plane down so the first deciding plane wins
    always_comb begin
        sph_verdict = VERDICT_IN;
        any_all     = 1'b0;
        all_none    = 1'b1;
        no_sph      = 1'b1;
        for (int p = PLANE_COUNT - 1; p >= 0; p--) begin
            if (i_flags[p].sph_out) begin
                sph_verdict = VERDICT_OUT;
            end else if (i_flags[p].sph_cross) begin
                sph_verdict = VERDICT_CROSS;
            end
            any_all  = any_all | i_flags[p].box_all;
            all_none = all_none & i_flags[p].box_none;
            no_sph   = no_sph & !i_flags[p].sph_out & !i_flags[p].sph_cross;
        end
        if (any_all) begin
            box_verdict = VERDICT_OUT;
        end else if (all_none) begin
            box_verdict = VERDICT_IN;
        end else begin
            box_verdict = VERDICT_CROSS;
        end
        n_verdict = i_func ? box_verdict : sph_verdict;
    end

    logic                 r_valid;
    logic [VERDICT_W-1:0] r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

    a_verdict_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_verdict == VERDICT_OUT || r_verdict == VERDICT_CROSS ||
                     r_verdict == VERDICT_IN))
        else $error("verdict code out of range");

    a_box_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_func && any_all) |=> (r_valid && r_verdict == VERDICT_OUT))
        else $error("box behind a plane not reported outside");

    a_box_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_func && all_none) |=> (r_valid && r_verdict == VERDICT_IN))
        else $error("box clear of all planes not reported inside");

    a_sph_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_func && no_sph) |=> (r_valid && r_verdict == VERDICT_IN))
        else $error("undecided sphere not reported inside");

endmodule

[rtl/frustum_cull_classifier_unit.sv]
// Channel  Direction  Handshake                   Payload
// input    in         start high, busy low        i_func, i_x/y/z_lo, i_x/y/z_hi, i_radius
// config   in         i_cfg_valid & o_cfg_ready   i_cfg_index, i_cfg_data
// result   out        o_valid strobe, one cycle   o_verdict
//
// One item enters per cycle; busy stays low. Each result passes in order through the
// input register, multiply, corner select and xy sum, z and offset add with compare,
// and verdict register. One multiplier pair per axis per plane sets the depth.
// Synchronous active-low reset clears the valid pipeline and the planes to zero.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module frustum_cull_classifier_unit #(
    parameter int PLANE_COUNT = fcc_pkg::NUM_PLANES,
    parameter int COORD_BITS  = fcc_pkg::DEFAULT_COORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_func,
    input  logic signed [COORD_BITS-1:0]       i_x_lo,
    input  logic signed [COORD_BITS-1:0]       i_y_lo,
    input  logic signed [COORD_BITS-1:0]       i_z_lo,
    input  logic signed [COORD_BITS-1:0]       i_x_hi,
    input  logic signed [COORD_BITS-1:0]       i_y_hi,
    input  logic signed [COORD_BITS-1:0]       i_z_hi,
    input  logic [fcc_pkg::RADIUS_W-1:0]       i_radius,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fcc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fcc_pkg::PLANE_W-1:0]        i_cfg_data,
    output logic                               o_valid,
    output logic [fcc_pkg::VERDICT_W-1:0]      o_verdict
);
    import fcc_pkg::*;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic accept;
    assign accept = start && !busy;

    logic [PLANE_COUNT-1:0][PLANE_W-1:0] planes;

    fcc_plane_regs #(
        .PLANE_COUNT(PLANE_COUNT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_planes(planes)
    );

    // Input register
    logic signed [COORD_BITS-1:0] r_x_lo, r_y_lo, r_z_lo, r_x_hi, r_y_hi, r_z_hi;
    logic [RADIUS_W-1:0]          r_rad_s0, r_rad_s1, r_rad_s2;
    logic [3:0]                   r_vld;
    logic [3:0]                   r_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_lo   <= i_x_lo;
        r_y_lo   <= i_y_lo;
        r_z_lo   <= i_z_lo;
        r_x_hi   <= i_x_hi;
        r_y_hi   <= i_y_hi;
        r_z_hi   <= i_z_hi;
        r_rad_s0 <= i_radius;
        r_rad_s1 <= r_rad_s0;
        r_rad_s2 <= r_rad_s1;
        r_func   <= {r_func[2:0], i_func};
    end

    t_plane_flags [PLANE_COUNT-1:0] flags;

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
        fcc_plane_lane #(
            .COORD_BITS(COORD_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_plane (planes[p]),
            .i_x_lo  (r_x_lo),
            .i_y_lo  (r_y_lo),
            .i_z_lo  (r_z_lo),
            .i_x_hi  (r_x_hi),
            .i_y_hi  (r_y_hi),
            .i_z_hi  (r_z_hi),
            .i_radius(r_rad_s2),
            .o_flags (flags[p])
        );
    end

    fcc_verdict #(
        .PLANE_COUNT(PLANE_COUNT)
    ) u_verdict (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld[3]),
        .i_func   (r_func[3]),
        .i_flags  (flags),
        .o_valid  (o_valid),
        .o_verdict(o_verdict)
    );

endmodule
